### hdl/rgbgh_pkg.sv
// ============================================================================
// rgbgh_pkg
// Shared constants, codes and types for the RGB to gray converter with
// per-channel histograms.
// ============================================================================
package rgbgh_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int BIN_COUNT   = 256;
    localparam int BIN_BITS    = $clog2(BIN_COUNT);
    localparam int PIX_BITS    = 8;
    localparam int RESULT_BITS = 32;
    localparam int CHAN_NUM    = 4;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int O_PTR_BITS  = $clog2(OUT_DEPTH);
    localparam int O_CNT_BITS  = $clog2(OUT_DEPTH + 1);

    localparam int WEIGHT_BITS = 16;
    localparam int PROD_BITS   = WEIGHT_BITS + PIX_BITS;
    localparam int SUM_BITS    = PROD_BITS + 1;
    localparam int FRAC_BITS   = 16;

    localparam logic [WEIGHT_BITS-1:0] W_RED   = 16'd13763;
    localparam logic [WEIGHT_BITS-1:0] W_GREEN = 16'd47186;
    localparam logic [WEIGHT_BITS-1:0] W_BLUE  = 16'd4588;

    localparam logic [PIX_BITS-1:0] GRAY_MAX = '1;

    typedef logic [COUNT_BITS-1:0] count_t;
    localparam count_t COUNT_MAX = '1;

    typedef enum logic [0:0] {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_GRAY  = 2'd3
    } channel_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [PIX_BITS-1:0]   red;
        logic [PIX_BITS-1:0]   green;
        logic [PIX_BITS-1:0]   blue;
        logic [PIX_BITS-1:0]   gray;
        channel_t              channel;
        logic [BIN_BITS-1:0]   bin;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } qpush_t;

    typedef struct packed {
        logic                  nonempty;
        logic [Q_CNT_BITS-1:0] count;
    } qstat_t;

    typedef struct packed {
        logic [PIX_BITS-1:0]    gray;
        logic [RESULT_BITS-1:0] count;
    } result_t;

endpackage

### hdl/rgbgh_if.sv
// ============================================================================
// rgbgh channel interfaces
// Pixel/command channel and result channel, valid/ready handshake.
// ============================================================================
interface rgbgh_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [rgbgh_pkg::PIX_BITS-1:0] red_in;
    logic [rgbgh_pkg::PIX_BITS-1:0] green_in;
    logic [rgbgh_pkg::PIX_BITS-1:0] blue_in;
    logic [1:0]                    channel_sel;
    logic [rgbgh_pkg::BIN_BITS-1:0] bin_index;

    modport source (
        output valid, opcode, red_in, green_in, blue_in, channel_sel, bin_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, red_in, green_in, blue_in, channel_sel, bin_index,
        output ready
    );
endinterface

interface rgbgh_out_if;
    logic                             valid;
    logic                             ready;
    logic [rgbgh_pkg::PIX_BITS-1:0]    gray_out;
    logic [rgbgh_pkg::RESULT_BITS-1:0] bin_count;

    modport source (
        output valid, gray_out, bin_count,
        input  ready
    );
    modport sink (
        input  valid, gray_out, bin_count,
        output ready
    );
endinterface

### hdl/rgbgh_front.sv
// ============================================================================
// rgbgh_front
// Accepts beats, forms the weighted products and the saturated gray level,
// and pushes classified entries into the work queue.
// ============================================================================
module rgbgh_front (
    input  logic                clk,
    input  logic                rst_n,
    rgbgh_in_if.sink            pixel,
    input  rgbgh_pkg::qstat_t   q_stat,
    output rgbgh_pkg::qpush_t   q_push
);

    logic                              f1_valid_reg;
    logic                              f1_valid_next;
    rgbgh_pkg::entry_t                 f1_entry_reg;
    logic [rgbgh_pkg::PROD_BITS-1:0]   prod_r_reg;
    logic [rgbgh_pkg::PROD_BITS-1:0]   prod_g_reg;
    logic [rgbgh_pkg::PROD_BITS-1:0]   prod_b_reg;
    logic [rgbgh_pkg::SUM_BITS-1:0]    sum;
    logic [rgbgh_pkg::SUM_BITS-rgbgh_pkg::FRAC_BITS-1:0] level;
    logic                              accept;
    logic [rgbgh_pkg::Q_CNT_BITS:0]    inflight;

    assign inflight      = (rgbgh_pkg::Q_CNT_BITS+1)'(q_stat.count)
                         + (rgbgh_pkg::Q_CNT_BITS+1)'(f1_valid_reg);
    assign pixel.ready   = inflight < (rgbgh_pkg::Q_CNT_BITS+1)'(rgbgh_pkg::Q_DEPTH);
    assign accept        = pixel.valid && pixel.ready;
    assign f1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_entry_reg.opcode  <= rgbgh_pkg::opcode_t'(pixel.opcode);
            f1_entry_reg.red     <= pixel.red_in;
            f1_entry_reg.green   <= pixel.green_in;
            f1_entry_reg.blue    <= pixel.blue_in;
            f1_entry_reg.gray    <= '0;
            f1_entry_reg.channel <= rgbgh_pkg::channel_t'(pixel.channel_sel);
            f1_entry_reg.bin     <= pixel.bin_index;
            prod_r_reg <= rgbgh_pkg::PROD_BITS'(pixel.red_in)
                        * rgbgh_pkg::PROD_BITS'(rgbgh_pkg::W_RED);
            prod_g_reg <= rgbgh_pkg::PROD_BITS'(pixel.green_in)
                        * rgbgh_pkg::PROD_BITS'(rgbgh_pkg::W_GREEN);
            prod_b_reg <= rgbgh_pkg::PROD_BITS'(pixel.blue_in)
                        * rgbgh_pkg::PROD_BITS'(rgbgh_pkg::W_BLUE);
        end
    end

    assign sum   = rgbgh_pkg::SUM_BITS'(prod_r_reg) + rgbgh_pkg::SUM_BITS'(prod_g_reg)
                 + rgbgh_pkg::SUM_BITS'(prod_b_reg);
    assign level = sum[rgbgh_pkg::SUM_BITS-1:rgbgh_pkg::FRAC_BITS];

    always_comb
    begin
        q_push.valid = f1_valid_reg;
        q_push.entry = f1_entry_reg;
        if (level > $bits(level)'(rgbgh_pkg::GRAY_MAX))
        begin
            q_push.entry.gray = rgbgh_pkg::GRAY_MAX;
        end
        else
        begin
            q_push.entry.gray = level[rgbgh_pkg::PIX_BITS-1:0];
        end
    end

endmodule

### hdl/rgbgh_queue.sv
// ============================================================================
// rgbgh_queue
// Short queue of classified entries between the front and back parts.
// ============================================================================
module rgbgh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  rgbgh_pkg::qpush_t   q_push,
    input  logic                q_pop,
    output rgbgh_pkg::entry_t   q_head,
    output rgbgh_pkg::qstat_t   q_stat
);

    rgbgh_pkg::entry_t                 slot_reg [rgbgh_pkg::Q_DEPTH];
    logic [rgbgh_pkg::Q_PTR_BITS-1:0]  wptr_reg;
    logic [rgbgh_pkg::Q_PTR_BITS-1:0]  wptr_next;
    logic [rgbgh_pkg::Q_PTR_BITS-1:0]  rptr_reg;
    logic [rgbgh_pkg::Q_PTR_BITS-1:0]  rptr_next;
    logic [rgbgh_pkg::Q_CNT_BITS-1:0]  cnt_reg;
    logic [rgbgh_pkg::Q_CNT_BITS-1:0]  cnt_next;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (q_push.valid)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (q_push.valid && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!q_push.valid && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            slot_reg[wptr_reg] <= q_push.entry;
        end
    end

    assign q_head         = slot_reg[rptr_reg];
    assign q_stat.nonempty = cnt_reg != '0;
    assign q_stat.count    = cnt_reg;

endmodule

### hdl/rgbgh_back.sv
// ============================================================================
// rgbgh_back
// Histogram memories with read-modify-write and forwarding, a clearing pass
// after reset, and the result skid buffer.
// ============================================================================
module rgbgh_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rgbgh_pkg::entry_t   q_head,
    input  rgbgh_pkg::qstat_t   q_stat,
    output logic                q_pop,
    rgbgh_out_if.source         result
);

    rgbgh_pkg::count_t                hist_mem [rgbgh_pkg::CHAN_NUM][rgbgh_pkg::BIN_COUNT];
    logic                             clr_busy_reg;
    logic [rgbgh_pkg::BIN_BITS-1:0]   clr_addr_reg;

    logic [rgbgh_pkg::BIN_BITS-1:0]   addr        [rgbgh_pkg::CHAN_NUM];
    logic [rgbgh_pkg::BIN_BITS-1:0]   s1_addr_reg [rgbgh_pkg::CHAN_NUM];
    rgbgh_pkg::count_t                rdata_reg   [rgbgh_pkg::CHAN_NUM];
    logic                             s1_valid_reg;
    rgbgh_pkg::entry_t                s1_entry_reg;

    logic                             wr_valid_reg;
    logic [rgbgh_pkg::BIN_BITS-1:0]   wr_addr_reg [rgbgh_pkg::CHAN_NUM];
    rgbgh_pkg::count_t                wr_data_reg [rgbgh_pkg::CHAN_NUM];

    rgbgh_pkg::count_t                cur [rgbgh_pkg::CHAN_NUM];
    rgbgh_pkg::count_t                upd [rgbgh_pkg::CHAN_NUM];
    logic                             wr_en;
    rgbgh_pkg::count_t                sel_count;
    rgbgh_pkg::result_t               res;

    rgbgh_pkg::result_t               ofifo_reg [rgbgh_pkg::OUT_DEPTH];
    logic [rgbgh_pkg::O_PTR_BITS-1:0] owptr_reg;
    logic [rgbgh_pkg::O_PTR_BITS-1:0] orptr_reg;
    logic [rgbgh_pkg::O_CNT_BITS-1:0] ocnt_reg;
    logic [rgbgh_pkg::O_CNT_BITS-1:0] ocnt_next;
    logic                             out_pop;
    logic [rgbgh_pkg::O_CNT_BITS:0]   pending;

    // hold back the queue during clearing and unless the skid buffer has room
    // for every beat in flight
    assign pending = (rgbgh_pkg::O_CNT_BITS+1)'(ocnt_reg)
                   + (rgbgh_pkg::O_CNT_BITS+1)'(s1_valid_reg);
    assign q_pop   = !clr_busy_reg && q_stat.nonempty
                   && (pending < (rgbgh_pkg::O_CNT_BITS+1)'(rgbgh_pkg::OUT_DEPTH));

    always_comb
    begin
        addr[rgbgh_pkg::CH_RED]   = q_head.red;
        addr[rgbgh_pkg::CH_GREEN] = q_head.green;
        addr[rgbgh_pkg::CH_BLUE]  = q_head.blue;
        addr[rgbgh_pkg::CH_GRAY]  = q_head.gray;
        if (q_head.opcode == rgbgh_pkg::OP_READ)
        begin
            for (int c = 0; c < rgbgh_pkg::CHAN_NUM; c++)
            begin
                addr[c] = q_head.bin;
            end
        end
    end

    // forward the previous cycle's write to a read that missed it
    always_comb
    begin
        for (int c = 0; c < rgbgh_pkg::CHAN_NUM; c++)
        begin
            if (wr_valid_reg && (wr_addr_reg[c] == s1_addr_reg[c]))
            begin
                cur[c] = wr_data_reg[c];
            end
            else
            begin
                cur[c] = rdata_reg[c];
            end
            if (cur[c] == rgbgh_pkg::COUNT_MAX)
            begin
                upd[c] = cur[c];
            end
            else
            begin
                upd[c] = cur[c] + rgbgh_pkg::count_t'(1);
            end
        end
    end

    assign wr_en = s1_valid_reg && (s1_entry_reg.opcode == rgbgh_pkg::OP_ACCUM);

    always_comb
    begin
        unique case (s1_entry_reg.channel)
            rgbgh_pkg::CH_RED:   sel_count = cur[rgbgh_pkg::CH_RED];
            rgbgh_pkg::CH_GREEN: sel_count = cur[rgbgh_pkg::CH_GREEN];
            rgbgh_pkg::CH_BLUE:  sel_count = cur[rgbgh_pkg::CH_BLUE];
            rgbgh_pkg::CH_GRAY:  sel_count = cur[rgbgh_pkg::CH_GRAY];
            default:             sel_count = '0;
        endcase
        if (s1_entry_reg.opcode == rgbgh_pkg::OP_READ)
        begin
            res.gray  = '0;
            res.count = rgbgh_pkg::RESULT_BITS'(sel_count);
        end
        else
        begin
            res.gray  = s1_entry_reg.gray;
            res.count = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < rgbgh_pkg::CHAN_NUM; c++)
        begin
            if (q_pop)
            begin
                rdata_reg[c]   <= hist_mem[c][addr[c]];
                s1_addr_reg[c] <= addr[c];
            end
            if (clr_busy_reg)
            begin
                hist_mem[c][clr_addr_reg] <= '0;
            end
            else if (wr_en)
            begin
                hist_mem[c][s1_addr_reg[c]] <= upd[c];
            end
            wr_addr_reg[c] <= s1_addr_reg[c];
            wr_data_reg[c] <= upd[c];
        end
        if (q_pop)
        begin
            s1_entry_reg <= q_head;
        end
        if (s1_valid_reg)
        begin
            ofifo_reg[owptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == rgbgh_pkg::BIN_BITS'(rgbgh_pkg::BIN_COUNT - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            s1_valid_reg <= q_pop;
            wr_valid_reg <= wr_en;
        end
    end

    assign out_pop = result.valid && result.ready;

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (s1_valid_reg && !out_pop)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (!s1_valid_reg && out_pop)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owptr_reg <= '0;
            orptr_reg <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                owptr_reg <= owptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                orptr_reg <= orptr_reg + 1'b1;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    assign result.valid     = ocnt_reg != '0;
    assign result.gray_out  = ofifo_reg[orptr_reg].gray;
    assign result.bin_count = ofifo_reg[orptr_reg].count;

endmodule

### hdl/rgb_gray_histogram_top.sv
// ============================================================================
// rgb_gray_histogram_top
// RGB to gray conversion with red, green, blue and gray histograms.
//
//   Channel  Dir  Contents
//   pixel    in   opcode, red_in, green_in, blue_in, channel_sel, bin_index
//   result   out  gray_out, bin_count
//
// One beat per cycle sustained while results are taken and no clearing pass
// runs; a beat's result passes the product register, a queue slot and the
// histogram read register and is held in the skid buffer until taken.
// The rate is set by the single read-modify-write pass per histogram memory,
// with the previous write forwarded to a back-to-back update of the same bin.
// Reset starts a clearing pass that zeroes every bin; beats queue up
// meanwhile and pixel.ready drops once the queue is full.
// A stalled result side fills the skid buffer and then the queue before
// pixel.ready drops.
// ============================================================================
module rgb_gray_histogram_top (
    input  logic        clk,
    input  logic        rst_n,
    rgbgh_in_if.sink    pixel,
    rgbgh_out_if.source result
);

    rgbgh_pkg::qpush_t q_push;
    rgbgh_pkg::qstat_t q_stat;
    rgbgh_pkg::entry_t q_head;
    logic              q_pop;

    rgbgh_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel),
        .q_stat (q_stat),
        .q_push (q_push)
    );

    rgbgh_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_pop  (q_pop),
        .q_head (q_head),
        .q_stat (q_stat)
    );

    rgbgh_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_head (q_head),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .result (result)
    );

endmodule
